/* design/three_address_instruction_executor_macros.svh */
// Assertion macros for the three-address instruction executor.
// Included by the design file that carries concurrent assertions; needs clk and rst_n in scope.
`ifndef THREE_ADDRESS_INSTRUCTION_EXECUTOR_MACROS_SVH
`define THREE_ADDRESS_INSTRUCTION_EXECUTOR_MACROS_SVH

// same-cycle implication
`define TAE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tae_pkg.sv */
// Shared types, opcodes and sizes for the three-address instruction executor.
// No dependencies; imported by the top level, tae_exec and the testbench.
`default_nettype none

package tae_pkg;

  localparam int unsigned NUM_VARIABLES = 64;
  localparam int unsigned PROGRAM_DEPTH = 1024;
  localparam int unsigned VAR_AW        = $clog2(NUM_VARIABLES);
  localparam int unsigned LINE_W        = 11;
  localparam int unsigned DATA_W        = 32;

  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_JUMP    = 4'd1;
  localparam logic [3:0] OP_READ    = 4'd2;
  localparam logic [3:0] OP_WRITE   = 4'd3;
  localparam logic [3:0] OP_ASSIGN  = 4'd4;
  localparam logic [3:0] OP_JUMPT   = 4'd5;
  localparam logic [3:0] OP_JUMPF   = 4'd6;
  localparam logic [3:0] OP_ADD     = 4'd7;
  localparam logic [3:0] OP_SUB     = 4'd8;
  localparam logic [3:0] OP_MUL     = 4'd9;
  localparam logic [3:0] OP_LT      = 4'd10;
  localparam logic [3:0] OP_GT      = 4'd11;
  localparam logic [3:0] OP_LTE     = 4'd12;
  localparam logic [3:0] OP_GTE     = 4'd13;
  localparam logic [3:0] OP_EQ      = 4'd14;
  localparam logic [3:0] OP_UNKNOWN = 4'd15;

  localparam logic [1:0] KIND_VAR = 2'd0;
  localparam logic [1:0] KIND_NUM = 2'd1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_INSTR   = 3'd1,
    ST_BAD_OPERAND = 3'd2,
    ST_MISSING     = 3'd3,
    ST_BAD_JUMP    = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [1:0]        first_kind;
    logic [DATA_W-1:0] first_value;
    logic [1:0]        second_kind;
    logic [DATA_W-1:0] second_value;
    logic [1:0]        third_kind;
    logic [DATA_W-1:0] third_value;
    logic [DATA_W-1:0] entered_value;
  } instr_t;

  typedef struct packed {
    status_t           status;
    logic [LINE_W-1:0] next_line;
    logic              finished;
    logic              shown_valid;
    logic [DATA_W-1:0] shown_value;
    logic              wr_en;
    logic [VAR_AW-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } exec_res_t;

endpackage

`default_nettype wire

/* design/three_address_instruction_executor.sv */
// Top level of the three-address instruction executor: input stage, variable store,
// counter and result register. Depends on tae_pkg, tae_ram, tae_exec and the macro header.
//
// Usage:
//  - cfg_valid/cfg_ready/cfg_data write the program length; cfg_ready is always high.
//    Write it only while no instruction is in flight.
//  - in_* carries one decoded instruction per beat, for the line at the current counter.
//  - out_* returns one beat per instruction: status, next line, finished flag and the
//    value shown by a write.
//  - An input beat passes the input stage, then the result register; one instruction is
//    accepted every cycle while out_ready is high. Variable reads start in the store's
//    registered read ports at input acceptance; the store write just ahead is bypassed.
//  - Reset clears the counter, the program length and all variable present bits; the
//    store contents are not cleared and no clearing pass runs.
//  - When out_ready is low the result register holds; the input stage fills, then
//    in_ready drops until the result is taken.
`default_nettype none

`include "three_address_instruction_executor_macros.svh"

module three_address_instruction_executor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tae_pkg::LINE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        in_action,
  input  logic [1:0]                        in_first_kind,
  input  logic signed [tae_pkg::DATA_W-1:0] in_first_value,
  input  logic [1:0]                        in_second_kind,
  input  logic signed [tae_pkg::DATA_W-1:0] in_second_value,
  input  logic [1:0]                        in_third_kind,
  input  logic signed [tae_pkg::DATA_W-1:0] in_third_value,
  input  logic signed [tae_pkg::DATA_W-1:0] in_entered_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [tae_pkg::LINE_W-1:0]        out_next_line,
  output logic                              out_finished,
  output logic                              out_shown_valid,
  output logic signed [tae_pkg::DATA_W-1:0] out_shown_value
);
  import tae_pkg::*;

  logic                     s1_v_r;
  instr_t                   s1_r;
  logic                     s1_adv, in_fire;
  logic [LINE_W-1:0]        len_r, eff_len;
  logic [LINE_W-1:0]        pc_r;
  logic [NUM_VARIABLES-1:0] present_r;
  logic                     byp_v_r;
  logic [VAR_AW-1:0]        byp_addr_r;
  logic [DATA_W-1:0]        byp_data_r;
  logic [DATA_W-1:0]        ram_a, ram_b, a_data, b_data;
  exec_res_t                res;
  logic                     out_v_r;
  exec_res_t                out_r;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || s1_adv;
  assign in_fire   = in_valid && in_ready;
  assign eff_len   = (DATA_W'(len_r) > DATA_W'(PROGRAM_DEPTH)) ? LINE_W'(PROGRAM_DEPTH) : len_r;

  tae_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_VARIABLES)
  ) u_store (
    .clk     (clk),
    .we      (s1_adv && res.wr_en),
    .waddr   (res.wr_addr),
    .wdata   (res.wr_data),
    .re      (in_fire),
    .raddr_a (in_first_value[VAR_AW-1:0]),
    .raddr_b (in_second_value[VAR_AW-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  assign a_data = (byp_v_r && (byp_addr_r == s1_r.first_value[VAR_AW-1:0])) ? byp_data_r : ram_a;
  assign b_data = (byp_v_r && (byp_addr_r == s1_r.second_value[VAR_AW-1:0])) ? byp_data_r : ram_b;

  tae_exec u_exec (
    .instr   (s1_r),
    .a_data  (a_data),
    .b_data  (b_data),
    .present (present_r),
    .pc      (pc_r),
    .eff_len (eff_len),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      byp_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      len_r     <= '0;
      pc_r      <= '0;
      present_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_data;
      end
      if (in_fire) begin
        s1_v_r  <= 1'b1;
        byp_v_r <= s1_adv && res.wr_en;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        pc_r    <= res.next_line;
        out_v_r <= 1'b1;
        if (res.wr_en) begin
          present_r[res.wr_addr] <= 1'b1;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.action        <= in_action;
      s1_r.first_kind    <= in_first_kind;
      s1_r.first_value   <= in_first_value;
      s1_r.second_kind   <= in_second_kind;
      s1_r.second_value  <= in_second_value;
      s1_r.third_kind    <= in_third_kind;
      s1_r.third_value   <= in_third_value;
      s1_r.entered_value <= in_entered_value;
      byp_addr_r         <= res.wr_addr;
      byp_data_r         <= res.wr_data;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_r.status;
  assign out_next_line   = out_r.next_line;
  assign out_finished    = out_r.finished;
  assign out_shown_valid = out_r.shown_valid;
  assign out_shown_value = out_r.shown_value;

  `TAE_ASSERT_NEXT(a_err_holds_pc, rst_n && s1_adv && (res.status != ST_OK), pc_r == $past(pc_r), "counter moved on error")
  `TAE_ASSERT_NEXT(a_write_sets_present, rst_n && s1_adv && res.wr_en, present_r[$past(res.wr_addr)], "store write left entry absent")
  `TAE_ASSERT_NOW(a_err_quiet, out_valid && (out_status != ST_OK), !out_finished && !out_shown_valid, "error beat shows or finishes")
  `TAE_ASSERT_NOW(a_err_no_write, s1_v_r && (res.status != ST_OK), !res.wr_en, "store written on error")

endmodule

`default_nettype wire

/* design/tae_ram.sv */
// Generic RAM: one write port, two registered read ports, no reset.
// No dependencies.
`default_nettype none

module tae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* design/tae_exec.sv */
// Execute unit: operand checks, ALU, jump resolution and next counter for one instruction.
// Depends on tae_pkg.
`default_nettype none

module tae_exec (
  input  tae_pkg::instr_t                       instr,
  input  logic [tae_pkg::DATA_W-1:0]            a_data,
  input  logic [tae_pkg::DATA_W-1:0]            b_data,
  input  logic [tae_pkg::NUM_VARIABLES-1:0]     present,
  input  logic [tae_pkg::LINE_W-1:0]            pc,
  input  logic [tae_pkg::LINE_W-1:0]            eff_len,
  output tae_pkg::exec_res_t                    res
);
  import tae_pkg::*;

  function automatic logic var_ok(input logic [DATA_W-1:0] v);
    var_ok = (v < DATA_W'(NUM_VARIABLES));
  endfunction

  function automatic status_t jump_check(input logic [1:0] kind, input logic [DATA_W-1:0] v,
                                         input logic [LINE_W-1:0] len);
    if (kind != KIND_NUM) begin
      jump_check = ST_BAD_OPERAND;
    end else if (v[DATA_W-1] || (v == '0) || (v > DATA_W'(len))) begin
      jump_check = ST_BAD_JUMP;
    end else begin
      jump_check = ST_OK;
    end
  endfunction

  logic [VAR_AW-1:0] idx1, idx2, idx3;
  logic              ok1, ok2, ok3;
  status_t           st, st_a, st_b, jst1, jst2;
  logic [DATA_W-1:0] val_a, val_b, alu;
  logic [LINE_W-1:0] tgt1, tgt2, tgt;
  logic              jumped, showv, wr_en, over, cond;
  logic [VAR_AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [LINE_W-1:0] pc_nxt;

  assign idx1 = instr.first_value[VAR_AW-1:0];
  assign idx2 = instr.second_value[VAR_AW-1:0];
  assign idx3 = instr.third_value[VAR_AW-1:0];
  assign ok1  = var_ok(instr.first_value);
  assign ok2  = var_ok(instr.second_value);
  assign ok3  = var_ok(instr.third_value);
  assign jst1 = jump_check(instr.first_kind, instr.first_value, eff_len);
  assign jst2 = jump_check(instr.second_kind, instr.second_value, eff_len);
  assign tgt1 = LINE_W'(instr.first_value - 1);
  assign tgt2 = LINE_W'(instr.second_value - 1);
  assign over = (pc >= eff_len);

  always_comb begin
    if (instr.first_kind == KIND_VAR) begin
      st_a  = !ok1 ? ST_BAD_OPERAND : (!present[idx1] ? ST_MISSING : ST_OK);
      val_a = a_data;
    end else begin
      st_a  = (instr.first_kind == KIND_NUM) ? ST_OK : ST_BAD_OPERAND;
      val_a = instr.first_value;
    end
    if (instr.second_kind == KIND_VAR) begin
      st_b  = !ok2 ? ST_BAD_OPERAND : (!present[idx2] ? ST_MISSING : ST_OK);
      val_b = b_data;
    end else begin
      st_b  = (instr.second_kind == KIND_NUM) ? ST_OK : ST_BAD_OPERAND;
      val_b = instr.second_value;
    end
  end

  always_comb begin
    case (instr.action)
      OP_ADD:  alu = val_a + val_b;
      OP_SUB:  alu = val_a - val_b;
      OP_MUL:  alu = val_a * val_b;
      OP_LT:   alu = DATA_W'($signed(val_a) < $signed(val_b));
      OP_GT:   alu = DATA_W'($signed(val_a) > $signed(val_b));
      OP_LTE:  alu = DATA_W'($signed(val_a) <= $signed(val_b));
      OP_GTE:  alu = DATA_W'($signed(val_a) >= $signed(val_b));
      default: alu = DATA_W'(val_a == val_b);
    endcase
  end

  assign cond = ((instr.action == OP_JUMPT) == (val_a != '0));

  always_comb begin
    st      = ST_OK;
    jumped  = 1'b0;
    tgt     = tgt1;
    showv   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = idx1;
    wr_data = instr.entered_value;
    unique case (instr.action) inside
      OP_NOP: begin
      end
      OP_JUMP: begin
        st     = jst1;
        jumped = 1'b1;
      end
      OP_READ: begin
        if ((instr.first_kind != KIND_VAR) || !ok1) begin
          st = ST_BAD_OPERAND;
        end else begin
          wr_en = 1'b1;
        end
      end
      OP_WRITE: begin
        if ((instr.first_kind != KIND_VAR) || !ok1) begin
          st = ST_BAD_OPERAND;
        end else if (!present[idx1]) begin
          st = ST_MISSING;
        end else begin
          showv = 1'b1;
        end
      end
      OP_ASSIGN: begin
        if ((instr.first_kind != KIND_VAR) || !ok1) begin
          st = ST_BAD_OPERAND;
        end else begin
          st      = st_b;
          wr_en   = (st_b == ST_OK);
          wr_data = val_b;
        end
      end
      OP_JUMPT, OP_JUMPF: begin
        st = st_a;
        if ((st_a == ST_OK) && cond) begin
          st     = jst2;
          jumped = 1'b1;
          tgt    = tgt2;
        end
      end
      OP_UNKNOWN: begin
        st = ST_BAD_INSTR;
      end
      default: begin
        if (st_a != ST_OK) begin
          st = st_a;
        end else if (st_b != ST_OK) begin
          st = st_b;
        end else if ((instr.third_kind != KIND_VAR) || !ok3) begin
          st = ST_BAD_OPERAND;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx3;
          wr_data = alu;
        end
      end
    endcase
  end

  assign pc_nxt = (jumped && (tgt != pc)) ? tgt : pc + LINE_W'(1);

  always_comb begin
    res.wr_addr     = wr_addr;
    res.wr_data     = wr_data;
    if (over) begin
      res.status      = ST_OK;
      res.next_line   = pc;
      res.finished    = 1'b1;
      res.shown_valid = 1'b0;
      res.shown_value = '0;
      res.wr_en       = 1'b0;
    end else if (st != ST_OK) begin
      res.status      = st;
      res.next_line   = pc;
      res.finished    = 1'b0;
      res.shown_valid = 1'b0;
      res.shown_value = '0;
      res.wr_en       = 1'b0;
    end else begin
      res.status      = ST_OK;
      res.next_line   = pc_nxt;
      res.finished    = (pc_nxt >= eff_len);
      res.shown_valid = showv;
      res.shown_value = showv ? a_data : '0;
      res.wr_en       = wr_en;
    end
  end

endmodule

`default_nettype wire

/* test/three_address_instruction_executor_test.sv */
// Self-checking testbench for the three-address instruction executor: directed and random
// decoded instructions against a cycle-free predictor of the variable store and counter.
// Depends on tae_pkg and the three_address_instruction_executor top level.
`timescale 1ns / 100ps

module three_address_instruction_executor_test;
  import tae_pkg::*;

  localparam logic [1:0] KIND_OTHER    = 2'd2;
  localparam int         DRAIN_CYCLES  = 6;
  localparam int         LONG_HOLD     = 80;
  localparam int         WATCHDOG_MAX  = 2000;
  localparam int         MAIN_LINES    = 175;
  localparam int         TAIL_LINES    = 12;
  localparam int         PHASES        = 6;

  typedef struct packed {
    status_t                  status;
    logic [LINE_W-1:0]        next_line;
    logic                     finished;
    logic                     shown_valid;
    logic signed [DATA_W-1:0] shown_value;
  } outcome_t;

  typedef struct {
    instr_t   ins;
    outcome_t outcome;
  } pending_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LINE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_action = '0;
  logic [1:0] in_first_kind = '0;
  logic signed [DATA_W-1:0] in_first_value = '0;
  logic [1:0] in_second_kind = '0;
  logic signed [DATA_W-1:0] in_second_value = '0;
  logic [1:0] in_third_kind = '0;
  logic signed [DATA_W-1:0] in_third_value = '0;
  logic signed [DATA_W-1:0] in_entered_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [LINE_W-1:0] out_next_line;
  logic out_finished;
  logic out_shown_valid;
  logic signed [DATA_W-1:0] out_shown_value;

  three_address_instruction_executor DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_first_kind    (in_first_kind),
    .in_first_value   (in_first_value),
    .in_second_kind   (in_second_kind),
    .in_second_value  (in_second_value),
    .in_third_kind    (in_third_kind),
    .in_third_value   (in_third_value),
    .in_entered_value (in_entered_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_next_line    (out_next_line),
    .out_finished     (out_finished),
    .out_shown_valid  (out_shown_valid),
    .out_shown_value  (out_shown_value)
  );

  // predictor state
  logic [DATA_W-1:0] var_value [NUM_VARIABLES];
  bit                var_known [NUM_VARIABLES];
  logic [LINE_W-1:0] model_pc;
  logic [LINE_W-1:0] model_len;

  pending_t pending_lines[$];
  outcome_t expected_lines[$];
  pending_t staged;
  outcome_t offered_outcome;
  outcome_t want;
  int  items_made = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  send_gap = 0;
  int  recv_hold = 0;
  int  hold;
  int  quiet_cycles = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  bit  failed = 1'b0;

  function automatic logic [LINE_W-1:0] active_length();
    return (model_len > LINE_W'(PROGRAM_DEPTH)) ? LINE_W'(PROGRAM_DEPTH) : model_len;
  endfunction

  function automatic bit var_slot(logic [DATA_W-1:0] v, output int unsigned idx);
    idx = 0;
    if (v[DATA_W-1] || v >= NUM_VARIABLES) return 1'b0;
    idx = v;
    return 1'b1;
  endfunction

  function automatic status_t read_source(logic [1:0] kind, logic [DATA_W-1:0] v,
                                          output logic [DATA_W-1:0] val);
    int unsigned idx;
    val = '0;
    if (kind == KIND_NUM) begin
      val = v;
      return ST_OK;
    end
    if (kind != KIND_VAR || !var_slot(v, idx)) return ST_BAD_OPERAND;
    if (!var_known[idx]) return ST_MISSING;
    val = var_value[idx];
    return ST_OK;
  endfunction

  function automatic status_t check_target(logic [1:0] kind, logic [DATA_W-1:0] v,
                                           output logic [LINE_W-1:0] tgt);
    logic [DATA_W-1:0] line0;
    tgt = '0;
    if (kind != KIND_NUM) return ST_BAD_OPERAND;
    line0 = v - 1;
    if (v[DATA_W-1] || v == 0 || line0 >= DATA_W'(active_length())) return ST_BAD_JUMP;
    tgt = line0[LINE_W-1:0];
    return ST_OK;
  endfunction

  function automatic outcome_t execute_line(instr_t ins);
    outcome_t          r;
    status_t           st;
    logic [DATA_W-1:0] a, b, res;
    logic [LINE_W-1:0] tgt, len;
    int unsigned       idx;
    bit                jumped;
    len = active_length();
    st = ST_OK;
    a = '0;
    b = '0;
    res = '0;
    tgt = '0;
    idx = 0;
    jumped = 1'b0;
    r.status = ST_OK;
    r.next_line = model_pc;
    r.finished = 1'b0;
    r.shown_valid = 1'b0;
    r.shown_value = '0;
    if (model_pc >= len) begin
      r.finished = 1'b1;
      return r;
    end
    case (ins.action)
      OP_NOP: ;
      OP_JUMP: begin
        st = check_target(ins.first_kind, ins.first_value, tgt);
        jumped = 1'b1;
      end
      OP_READ: begin
        if (ins.first_kind != KIND_VAR || !var_slot(ins.first_value, idx)) begin
          st = ST_BAD_OPERAND;
        end else begin
          var_value[idx] = ins.entered_value;
          var_known[idx] = 1'b1;
        end
      end
      OP_WRITE: begin
        if (ins.first_kind != KIND_VAR || !var_slot(ins.first_value, idx)) begin
          st = ST_BAD_OPERAND;
        end else if (!var_known[idx]) begin
          st = ST_MISSING;
        end else begin
          r.shown_valid = 1'b1;
          r.shown_value = var_value[idx];
        end
      end
      OP_ASSIGN: begin
        if (ins.first_kind != KIND_VAR || !var_slot(ins.first_value, idx)) begin
          st = ST_BAD_OPERAND;
        end else begin
          st = read_source(ins.second_kind, ins.second_value, a);
          if (st == ST_OK) begin
            var_value[idx] = a;
            var_known[idx] = 1'b1;
          end
        end
      end
      OP_JUMPT, OP_JUMPF: begin
        st = read_source(ins.first_kind, ins.first_value, a);
        if (st == ST_OK && ((ins.action == OP_JUMPT) == (a != 0))) begin
          st = check_target(ins.second_kind, ins.second_value, tgt);
          jumped = 1'b1;
        end
      end
      OP_UNKNOWN: st = ST_BAD_INSTR;
      default: begin
        st = read_source(ins.first_kind, ins.first_value, a);
        if (st == ST_OK) st = read_source(ins.second_kind, ins.second_value, b);
        if (st == ST_OK && (ins.third_kind != KIND_VAR || !var_slot(ins.third_value, idx)))
          st = ST_BAD_OPERAND;
        if (st == ST_OK) begin
          case (ins.action)
            OP_ADD:  res = a + b;
            OP_SUB:  res = a - b;
            OP_MUL:  res = a * b;
            OP_LT:   res = {31'b0, $signed(a) < $signed(b)};
            OP_GT:   res = {31'b0, $signed(a) > $signed(b)};
            OP_LTE:  res = {31'b0, $signed(a) <= $signed(b)};
            OP_GTE:  res = {31'b0, $signed(a) >= $signed(b)};
            default: res = {31'b0, a == b};
          endcase
          var_value[idx] = res;
          var_known[idx] = 1'b1;
        end
      end
    endcase
    if (st != ST_OK) begin
      r.status = st;
      r.shown_valid = 1'b0;
      r.shown_value = '0;
      return r;
    end
    model_pc = (jumped && tgt != model_pc) ? tgt : model_pc + 1'b1;
    r.next_line = model_pc;
    r.finished = (model_pc >= len);
    return r;
  endfunction

  function automatic void queue_line(instr_t ins);
    pending_t p;
    p.ins = ins;
    p.outcome = execute_line(ins);
    pending_lines.insert(pending_lines.size(), p);
    items_made++;
  endfunction

  function automatic instr_t pack_line(logic [3:0] act, logic [1:0] k1, logic [DATA_W-1:0] v1,
                                       logic [1:0] k2, logic [DATA_W-1:0] v2,
                                       logic [1:0] k3, logic [DATA_W-1:0] v3,
                                       logic [DATA_W-1:0] ent);
    instr_t ins;
    ins.action = act;
    ins.first_kind = k1;
    ins.first_value = v1;
    ins.second_kind = k2;
    ins.second_value = v2;
    ins.third_kind = k3;
    ins.third_value = v3;
    ins.entered_value = ent;
    return ins;
  endfunction

  function automatic logic [DATA_W-1:0] any_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] bad_index();
    if ($urandom_range(0, 1)) return NUM_VARIABLES + $urandom_range(0, 1000);
    return $urandom() | 32'h8000_0000;
  endfunction

  function automatic logic [DATA_W-1:0] known_var();
    int unsigned k;
    int          t;
    for (t = 0; t < 8; t++) begin
      k = $urandom_range(0, 15);
      if (var_known[k]) return k;
    end
    return $urandom_range(0, NUM_VARIABLES - 1);
  endfunction

  function automatic void source_slot(output logic [1:0] kind, output logic [DATA_W-1:0] value);
    int unsigned r;
    r = $urandom_range(0, 99);
    kind = KIND_VAR;
    if (r < 55) value = known_var();
    else if (r < 63) value = $urandom_range(0, NUM_VARIABLES - 1);
    else if (r < 68) value = bad_index();
    else if (r < 96) begin
      kind = KIND_NUM;
      value = any_word();
    end else begin
      kind = KIND_OTHER;
      value = $urandom();
    end
  endfunction

  function automatic void dest_slot(output logic [1:0] kind, output logic [DATA_W-1:0] value);
    int unsigned r;
    r = $urandom_range(0, 99);
    kind = KIND_VAR;
    if (r < 70) value = $urandom_range(0, 15);
    else if (r < 90) value = $urandom_range(0, NUM_VARIABLES - 1);
    else if (r < 96) value = bad_index();
    else begin
      kind = $urandom_range(0, 1) ? KIND_NUM : KIND_OTHER;
      value = $urandom();
    end
  endfunction

  function automatic void target_slot(output logic [1:0] kind, output logic [DATA_W-1:0] value);
    int unsigned r, len;
    r = $urandom_range(0, 99);
    len = (active_length() == 0) ? 1 : active_length();
    kind = KIND_NUM;
    if (r < 60) value = $urandom_range(1, len);
    else if (r < 72) value = 32'(model_pc) + 1;
    else if (r < 80) value = len;
    else if (r < 90) begin
      case ($urandom_range(0, 3))
        0:       value = 0;
        1:       value = len + 1;
        2:       value = $urandom() | 32'h8000_0000;
        default: value = $urandom();
      endcase
    end else begin
      kind = (r < 95) ? KIND_VAR : KIND_OTHER;
      value = (r < 95) ? known_var() : $urandom();
    end
  endfunction

  function automatic instr_t make_random_line(bit keep_running);
    instr_t      ins;
    int unsigned r;
    ins = pack_line(OP_NOP, 2'($urandom_range(0, 2)), $urandom(), 2'($urandom_range(0, 2)),
                    $urandom(), 2'($urandom_range(0, 2)), $urandom(), any_word());
    if (keep_running && model_pc > 900) begin
      ins.action = OP_JUMP;
      ins.first_kind = KIND_NUM;
      ins.first_value = $urandom_range(1, 64);
      return ins;
    end
    r = $urandom_range(0, 99);
    if (r < 4) ins.action = OP_NOP;
    else if (r < 10) begin
      ins.action = OP_JUMP;
      target_slot(ins.first_kind, ins.first_value);
    end else if (r < 20) begin
      ins.action = OP_READ;
      dest_slot(ins.first_kind, ins.first_value);
    end else if (r < 28) begin
      ins.action = OP_WRITE;
      if ($urandom_range(0, 9) != 0) begin
        ins.first_kind = KIND_VAR;
        ins.first_value = known_var();
      end else dest_slot(ins.first_kind, ins.first_value);
    end else if (r < 38) begin
      ins.action = OP_ASSIGN;
      dest_slot(ins.first_kind, ins.first_value);
      source_slot(ins.second_kind, ins.second_value);
    end else if (r < 46) begin
      ins.action = $urandom_range(0, 1) ? OP_JUMPT : OP_JUMPF;
      source_slot(ins.first_kind, ins.first_value);
      target_slot(ins.second_kind, ins.second_value);
    end else if (r < 98) begin
      ins.action = 4'($urandom_range(OP_ADD, OP_EQ));
      source_slot(ins.first_kind, ins.first_value);
      source_slot(ins.second_kind, ins.second_value);
      dest_slot(ins.third_kind, ins.third_value);
    end else ins.action = OP_UNKNOWN;
    return ins;
  endfunction

  task automatic wait_drain();
    wait (beats_in == items_made && beats_out == beats_in);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LINE_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_len = v;
  endtask

  task automatic compare_field(input string field, input logic [DATA_W-1:0] expected_value,
                               input logic [DATA_W-1:0] actual_value);
    if (actual_value !== expected_value) begin
      failed = 1'b1;
      $error("%s: expected 0x%0h, got 0x%0h", field, expected_value, actual_value);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: present queued instructions, with a random gap, possibly none, after each beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_lines.insert(expected_lines.size(), offered_outcome);
        beats_in++;
        if (beats_in % 64 == 0) send_calm = ($urandom_range(0, 2) == 0);
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_lines.size() != 0) begin
          staged = pending_lines.pop_front();
          in_action <= staged.ins.action;
          in_first_kind <= staged.ins.first_kind;
          in_first_value <= staged.ins.first_value;
          in_second_kind <= staged.ins.second_kind;
          in_second_value <= staged.ins.second_value;
          in_third_kind <= staged.ins.third_kind;
          in_third_value <= staged.ins.third_value;
          in_entered_value <= staged.ins.entered_value;
          offered_outcome <= staged.outcome;
          in_valid <= 1'b1;
          send_gap <= send_calm ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, with a random stall, possibly none, after it
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold <= 0;
    end else if (out_valid && out_ready) begin
      beats_out++;
      if (expected_lines.size() == 0) begin
        failed = 1'b1;
        $error("result beat with no instruction outstanding");
      end else begin
        want = expected_lines.pop_front();
        compare_field("status", 32'(want.status), 32'(out_status));
        compare_field("next_line", 32'(want.next_line), 32'(out_next_line));
        compare_field("finished", 32'(want.finished), 32'(out_finished));
        compare_field("shown_valid", 32'(want.shown_valid), 32'(out_shown_valid));
        compare_field("shown_value", want.shown_value, out_shown_value);
      end
      if (beats_out % 64 == 0) recv_calm = ($urandom_range(0, 2) == 0);
      hold = recv_calm ? 0 : $urandom_range(0, 6);
      if (beats_out == 200 || beats_out == 700) hold = LONG_HOLD;
      recv_hold <= hold;
      out_ready <= (hold == 0);
    end else if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= (recv_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("three_address_instruction_executor_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    model_pc = '0;
    model_len = '0;
    for (int i = 0; i < NUM_VARIABLES; i++) begin
      var_known[i] = 1'b0;
      var_value[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero length: every line sees the run as over
    set_length(LINE_W'(0));
    queue_line(pack_line(OP_NOP, KIND_NUM, 0, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_READ, KIND_VAR, 0, KIND_NUM, 0, KIND_NUM, 0, 5));
    wait_drain();

    set_length(LINE_W'(PROGRAM_DEPTH));
    queue_line(pack_line(OP_NOP, KIND_OTHER, '1, KIND_OTHER, '1, KIND_OTHER, '1, '1));
    queue_line(pack_line(OP_READ, KIND_VAR, 0, KIND_NUM, 0, KIND_NUM, 0, 32'h7fff_ffff));
    queue_line(pack_line(OP_READ, KIND_VAR, 63, KIND_NUM, 0, KIND_NUM, 0, 32'h8000_0000));
    queue_line(pack_line(OP_WRITE, KIND_VAR, 0, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_WRITE, KIND_VAR, 63, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_WRITE, KIND_VAR, 5, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_WRITE, KIND_VAR, 64, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_READ, KIND_VAR, 32'hffff_ffff, KIND_NUM, 0, KIND_NUM, 0, 1));
    queue_line(pack_line(OP_READ, KIND_OTHER, 0, KIND_NUM, 0, KIND_NUM, 0, 1));
    queue_line(pack_line(OP_ASSIGN, KIND_VAR, 1, KIND_NUM, 32'hffff_ffff, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_ASSIGN, KIND_VAR, 2, KIND_VAR, 63, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_ADD, KIND_VAR, 0, KIND_NUM, 1, KIND_VAR, 4, 0));
    queue_line(pack_line(OP_SUB, KIND_VAR, 63, KIND_NUM, 1, KIND_VAR, 5, 0));
    queue_line(pack_line(OP_MUL, KIND_VAR, 0, KIND_VAR, 0, KIND_VAR, 6, 0));
    queue_line(pack_line(OP_LT, KIND_VAR, 63, KIND_VAR, 0, KIND_VAR, 7, 0));
    queue_line(pack_line(OP_GT, KIND_VAR, 63, KIND_VAR, 0, KIND_VAR, 8, 0));
    queue_line(pack_line(OP_LTE, KIND_VAR, 1, KIND_VAR, 1, KIND_VAR, 9, 0));
    queue_line(pack_line(OP_GTE, KIND_NUM, 32'hffff_ffff, KIND_NUM, 0, KIND_VAR, 10, 0));
    queue_line(pack_line(OP_EQ, KIND_VAR, 2, KIND_VAR, 63, KIND_VAR, 11, 0));
    queue_line(pack_line(OP_ADD, KIND_VAR, 0, KIND_VAR, 0, KIND_NUM, 12, 0));
    queue_line(pack_line(OP_UNKNOWN, KIND_NUM, 0, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_JUMPT, KIND_VAR, 7, KIND_NUM, PROGRAM_DEPTH, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_JUMPF, KIND_NUM, 0, KIND_NUM, 1, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_JUMP, KIND_NUM, 32'(model_pc) + 1, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_JUMP, KIND_NUM, PROGRAM_DEPTH + 1, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_JUMP, KIND_NUM, 0, KIND_NUM, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_JUMPT, KIND_NUM, 0, KIND_OTHER, 0, KIND_NUM, 0, 0));
    queue_line(pack_line(OP_JUMP, KIND_VAR, 0, KIND_NUM, 0, KIND_NUM, 0, 0));
    wait_drain();

    for (ph = 0; ph < PHASES; ph++) begin
      set_length(LINE_W'(PROGRAM_DEPTH));
      repeat (MAIN_LINES) queue_line(make_random_line(1'b1));
      wait_drain();
      // short program: run into the end and past it
      if (ph == 2) set_length(LINE_W'(1));
      else set_length(model_pc + LINE_W'($urandom_range(1, 6)));
      repeat (TAIL_LINES) queue_line(make_random_line(1'b0));
      wait_drain();
    end

    if (!failed && expected_lines.size() == 0) begin
      $display("three_address_instruction_executor_test: PASS");
    end else begin
      $display("three_address_instruction_executor_test: FAIL");
    end
    $finish;
  end

endmodule
